// ===== rtl/mm2_pkg.sv =====
// ----------------------------------------------------------------------------
// mm2_pkg: shared types and constants of the MurmurHash2 block
// Holds the mixing constants, the operation codes and the queue entry
// that the front end hands to the back end.
// ----------------------------------------------------------------------------
package mm2_pkg;

  localparam logic [31:0] MIX_M  = 32'h5bd1e995;
  localparam int          MIX_R  = 24;
  localparam int          FIN_R1 = 13;
  localparam int          FIN_R2 = 15;

  localparam logic [2:0]  FULL_BYTES = 3'd4;

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_TAIL = 2'd1,
    OP_FULL = 2'd2
  } mm2_op_t;

  typedef struct packed {
    mm2_op_t     op;
    logic        first;
    logic        last;
    logic [31:0] start;
    logic [31:0] data;
  } mm2_entry_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_ACC  = 4'b0010,
    ST_FMUL = 4'b0100,
    ST_FOUT = 4'b1000
  } mm2_state_t;

endpackage

// ===== rtl/mm2_front.sv =====
// ----------------------------------------------------------------------------
// mm2_front: input stage of the MurmurHash2 block
// Accepts key words, classifies them, marks each key's first word, carries the
// start value (seed xor length) and premixes full words in a two-stage multiplier pipeline.
// ----------------------------------------------------------------------------
module mm2_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_hash_seed,
  input  logic                in_push,
  output logic                in_full,
  input  logic [31:0]         in_key_word,
  input  logic [2:0]          in_word_bytes,
  input  logic [31:0]         in_total_length,
  input  logic                in_last_word,
  input  logic                q_full,
  output logic                q_push,
  output mm2_pkg::mm2_entry_t q_din
);

  logic [31:0]         hash_seed_r;
  logic                in_key_r;
  logic                va_r;
  logic                vb_r;
  mm2_pkg::mm2_entry_t ent_a_r;
  mm2_pkg::mm2_entry_t ent_b_r;
  mm2_pkg::mm2_entry_t ent_b_nxt;
  logic [31:0]         prod_a_r;
  logic [31:0]         k_mid;
  logic                adv;
  logic                acc;
  mm2_pkg::mm2_entry_t ent_in;

  function automatic logic [31:0] byte_mask(input logic [2:0] nb);
    logic [31:0] m;
    begin
      unique case (nb)
        3'd1:    m = 32'h0000_00ff;
        3'd2:    m = 32'h0000_ffff;
        3'd3:    m = 32'h00ff_ffff;
        default: m = 32'h0000_0000;
      endcase
      return m;
    end
  endfunction

  assign adv     = !vb_r || !q_full;
  assign in_full = !adv;
  assign acc     = in_push && adv;
  assign q_push  = vb_r && !q_full;
  assign q_din   = ent_b_r;
  assign k_mid   = prod_a_r ^ (prod_a_r >> mm2_pkg::MIX_R);

  always_comb begin
    ent_in.first = !in_key_r;
    ent_in.last  = in_last_word;
    ent_in.start = hash_seed_r ^ in_total_length;
    if (in_word_bytes >= mm2_pkg::FULL_BYTES) begin
      ent_in.op   = mm2_pkg::OP_FULL;
      ent_in.data = in_key_word;
    end else if (in_word_bytes == 3'd0) begin
      ent_in.op   = mm2_pkg::OP_NONE;
      ent_in.data = 32'd0;
    end else begin
      ent_in.op   = mm2_pkg::OP_TAIL;
      ent_in.data = in_key_word & byte_mask(in_word_bytes);
    end
  end

  always_comb begin
    ent_b_nxt = ent_a_r;
    if (ent_a_r.op == mm2_pkg::OP_FULL) begin
      ent_b_nxt.data = k_mid * mm2_pkg::MIX_M;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_seed_r <= 32'd0;
    end else if (cfg_we) begin
      hash_seed_r <= cfg_hash_seed;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_key_r <= 1'b0;
      va_r     <= 1'b0;
      vb_r     <= 1'b0;
    end else if (adv) begin
      va_r <= acc;
      vb_r <= va_r;
      if (acc) begin
        in_key_r <= !in_last_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (acc) begin
        ent_a_r  <= ent_in;
        prod_a_r <= in_key_word * mm2_pkg::MIX_M;
      end
      ent_b_r <= ent_b_nxt;
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_full))
    else $error("front pushed into a full queue");

  a_stage_b_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (vb_r && q_full) |=> vb_r && $stable(ent_b_r))
    else $error("stalled entry changed");

  a_in_key_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_last_word) |=> !in_key_r)
    else $error("key state not cleared after last word");

endmodule

// ===== rtl/mm2_fifo.sv =====
// ----------------------------------------------------------------------------
// mm2_fifo: entry queue between front end and back end
// A small register queue of classified key words.
// ----------------------------------------------------------------------------
module mm2_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  mm2_pkg::mm2_entry_t din,
  output logic                full,
  input  logic                rd_en,
  output mm2_pkg::mm2_entry_t dout,
  output logic                empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  mm2_pkg::mm2_entry_t mem_r [DEPTH];
  logic [AW-1:0]       wr_ptr_r;
  logic [AW-1:0]       rd_ptr_r;
  logic [CW-1:0]       count_r;
  logic                do_wr;
  logic                do_rd;

  assign full  = (count_r == FULL_CNT);
  assign empty = (count_r == '0);
  assign dout  = mem_r[rd_ptr_r];
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_r <= count_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("queue count out of range");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd_en && empty))
    else $error("queue read while empty");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (do_wr && !do_rd) |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count did not advance on write");

endmodule

// ===== rtl/mm2_back.sv =====
// ----------------------------------------------------------------------------
// mm2_back: hash recurrence and finalization of the MurmurHash2 block
// Takes classified words from the queue, updates the running hash with one
// shared multiplier, finalizes on a key's last word and holds the result.
// ----------------------------------------------------------------------------
module mm2_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  mm2_pkg::mm2_entry_t q_dout,
  output logic                q_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output logic [31:0]         out_hash_value
);

  mm2_pkg::mm2_state_t state_r;
  mm2_pkg::mm2_state_t state_nxt;
  mm2_pkg::mm2_entry_t ent_r;
  mm2_pkg::mm2_entry_t ent_nxt;
  logic [31:0]         h_r;
  logic [31:0]         h_nxt;
  logic [31:0]         prod_r;
  logic [31:0]         prod_nxt;
  logic                out_v_r;
  logic                out_v_nxt;
  logic [31:0]         out_r;
  logic [31:0]         out_nxt;
  logic [31:0]         h_in;
  logic [31:0]         mul_a;
  logic [31:0]         fin_val;

  assign h_in           = q_dout.first ? q_dout.start : h_r;
  assign fin_val        = prod_r ^ (prod_r >> mm2_pkg::FIN_R2);
  assign out_empty      = !out_v_r;
  assign out_hash_value = out_r;

  always_comb begin
    if (state_r == mm2_pkg::ST_FMUL) begin
      mul_a = h_r ^ (h_r >> mm2_pkg::FIN_R1);
    end else if (q_dout.op == mm2_pkg::OP_TAIL) begin
      mul_a = h_in ^ q_dout.data;
    end else begin
      mul_a = h_in;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ent_nxt   = ent_r;
    h_nxt     = h_r;
    prod_nxt  = prod_r;
    out_v_nxt = out_v_r && !out_pop;
    out_nxt   = out_r;
    q_pop     = 1'b0;
    unique case (state_r)
      mm2_pkg::ST_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          ent_nxt = q_dout;
          if (q_dout.op == mm2_pkg::OP_NONE) begin
            h_nxt     = h_in;
            state_nxt = q_dout.last ? mm2_pkg::ST_FMUL : mm2_pkg::ST_IDLE;
          end else begin
            prod_nxt  = mul_a * mm2_pkg::MIX_M;
            state_nxt = mm2_pkg::ST_ACC;
          end
        end
      end
      mm2_pkg::ST_ACC: begin
        h_nxt     = (ent_r.op == mm2_pkg::OP_FULL) ? (prod_r ^ ent_r.data) : prod_r;
        state_nxt = ent_r.last ? mm2_pkg::ST_FMUL : mm2_pkg::ST_IDLE;
      end
      mm2_pkg::ST_FMUL: begin
        prod_nxt  = mul_a * mm2_pkg::MIX_M;
        state_nxt = mm2_pkg::ST_FOUT;
      end
      mm2_pkg::ST_FOUT: begin
        if (!out_v_r || out_pop) begin
          out_nxt   = fin_val;
          out_v_nxt = 1'b1;
          h_nxt     = fin_val;
          state_nxt = mm2_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mm2_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mm2_pkg::ST_IDLE;
      out_v_r <= 1'b0;
      h_r     <= 32'd0;
    end else begin
      state_r <= state_nxt;
      out_v_r <= out_v_nxt;
      h_r     <= h_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r  <= ent_nxt;
    prod_r <= prod_nxt;
    out_r  <= out_nxt;
  end

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == mm2_pkg::ST_IDLE)
    else $error("queue popped outside idle state");

  a_fmul_to_fout: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mm2_pkg::ST_FMUL |=> state_r == mm2_pkg::ST_FOUT)
    else $error("finalization multiply not followed by output step");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mm2_pkg::ST_FOUT && !out_v_r) |=> out_v_r && state_r == mm2_pkg::ST_IDLE)
    else $error("finished hash not delivered to output register");

endmodule

// ===== rtl/murmur2_hash_32.sv =====
// ----------------------------------------------------------------------------
// murmur2_hash_32: streaming 32-bit MurmurHash2
// Hashes keys fed as little-endian 32-bit words and delivers one hash
// per key.
//
//   Channel  Direction  Handshake           Payload
//   in_      input      in_push / in_full   key_word, word_bytes,
//                                           total_length, last_word
//   out_     output     out_pop / out_empty hash_value
//   cfg_     input      cfg_we              hash_seed
//
// A word with data passes the back end as a shared multiply and then a combine,
// a word with no valid bytes only sets the running hash, and a key's last word
// adds a finalization multiply and an output step. An accepted transfer passes
// the two premix stages and the queue before it reaches the back end.
// Reset clears the seed, the key state, the queue and the result valid flag.
// The front end accepts words while its last premix stage is empty or the queue has
// room; an unpopped result stalls the back end, and the front end once the queue fills.
// ----------------------------------------------------------------------------
module murmur2_hash_32 #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_hash_seed,
  input  logic        in_push,
  output logic        in_full,
  input  logic [31:0] in_key_word,
  input  logic [2:0]  in_word_bytes,
  input  logic [31:0] in_total_length,
  input  logic        in_last_word,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [31:0] out_hash_value
);

  logic                q_push;
  logic                q_full;
  logic                q_pop;
  logic                q_empty;
  mm2_pkg::mm2_entry_t q_din;
  mm2_pkg::mm2_entry_t q_dout;

  mm2_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_hash_seed   (cfg_hash_seed),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_key_word     (in_key_word),
    .in_word_bytes   (in_word_bytes),
    .in_total_length (in_total_length),
    .in_last_word    (in_last_word),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_din           (q_din)
  );

  mm2_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_en (q_push),
    .din   (q_din),
    .full  (q_full),
    .rd_en (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  mm2_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_dout         (q_dout),
    .q_pop          (q_pop),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_hash_value (out_hash_value)
  );

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the streaming MurmurHash2 block
// Feeds keys as little-endian words under several seeds, with random gaps
// on the input side and random stalls on the result side. A tracker class
// keeps its own running hash per key and holds the expected hashes in
// order. Every popped hash is compared against the oldest one.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [31:0] MURMUR_M = 32'h5bd1e995;

  class hash_checker;
    logic [31:0] hash_seed;
    logic [31:0] running_hash;
    bit          in_key;
    logic [31:0] pending_hashes[$];
    int          mismatches;
    int          hashes_checked;

    function new();
      hash_seed      = '0;
      running_hash   = '0;
      in_key         = 1'b0;
      mismatches     = 0;
      hashes_checked = 0;
    endfunction

    function void note_word(logic [31:0] word, logic [2:0] nbytes, logic [31:0] len,
                            logic last);
      logic [31:0] h;
      logic [31:0] k;
      int unsigned n;
      n = (nbytes > 3'd4) ? 32'd4 : 32'(nbytes);
      h = in_key ? running_hash : (hash_seed ^ len);
      if (n == 4) begin
        k = word * MURMUR_M;
        k = k ^ (k >> 24);
        k = k * MURMUR_M;
        h = (h * MURMUR_M) ^ k;
      end else if (n != 0) begin
        h = h ^ (word & ((32'h1 << (8 * n)) - 32'h1));
        h = h * MURMUR_M;
      end
      if (last) begin
        h = h ^ (h >> 13);
        h = h * MURMUR_M;
        h = h ^ (h >> 15);
        pending_hashes.push_back(h);
        in_key = 1'b0;
      end else begin
        in_key = 1'b1;
      end
      running_hash = h;
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_hash(logic [31:0] got);
      logic [31:0] want;
      if (pending_hashes.size() == 0) begin
        report($sformatf("hash %08h arrived with none expected", got));
      end else begin
        want = pending_hashes.pop_front();
        hashes_checked++;
        if (got !== want) begin
          report($sformatf("hash_value %08h, expected %08h", got, want));
        end
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_hash_seed = '0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [31:0] in_key_word = '0;
  logic [2:0]  in_word_bytes = '0;
  logic [31:0] in_total_length = '0;
  logic        in_last_word = 1'b0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [31:0] out_hash_value;

  hash_checker tracker = new();
  bit          idle_on = 1'b1;
  int          words_sent = 0;
  int          keys_sent = 0;
  int          seeds_written = 0;

  murmur2_hash_32 uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_hash_seed   (cfg_hash_seed),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_key_word     (in_key_word),
    .in_word_bytes   (in_word_bytes),
    .in_total_length (in_total_length),
    .in_last_word    (in_last_word),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_hash_value  (out_hash_value)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && in_push && !in_full) begin
      tracker.note_word(in_key_word, in_word_bytes, in_total_length, in_last_word);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      tracker.check_hash(out_hash_value);
    end
  end

  initial begin
    int n;
    forever begin
      n = $urandom_range(1, 13);
      if (idle_on && $urandom_range(0, 2) == 0) begin
        repeat (n) begin
          @(negedge clk);
          out_pop <= 1'b0;
        end
      end else begin
        repeat (n) begin
          @(negedge clk);
          out_pop <= 1'b1;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("timeout: %0d hashes still outstanding", tracker.pending_hashes.size());
    $display("simulation failed");
    $finish;
  end

  task automatic put_word(input logic [31:0] word, input logic [2:0] nbytes,
                          input logic [31:0] len, input logic last);
    int n;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 13);
      repeat (n) begin
        @(negedge clk);
        in_push         <= 1'b0;
        in_key_word     <= $urandom;
        in_word_bytes   <= 3'($urandom_range(0, 7));
        in_total_length <= $urandom;
        in_last_word    <= 1'($urandom_range(0, 1));
      end
    end
    @(negedge clk);
    in_push         <= 1'b1;
    in_key_word     <= word;
    in_word_bytes   <= nbytes;
    in_total_length <= len;
    in_last_word    <= last;
    do @(posedge clk); while (in_full);
    words_sent++;
    if (last) keys_sent++;
  endtask

  // Broken keys carry odd byte counts mid-key, saturating counts and a
  // length field that may not match the words.
  task automatic send_key(input int unsigned nbytes, input bit broken);
    logic [31:0] len_field;
    logic [2:0]  nb;
    logic        last;
    int unsigned left;
    bit          first;
    len_field = (broken && $urandom_range(0, 1) == 1) ? 32'($urandom) : nbytes;
    left = nbytes;
    first = 1'b1;
    do begin
      nb = (left >= 4) ? 3'd4 : 3'(left);
      left -= nb;
      last = (left == 0);
      if (broken && !last && $urandom_range(0, 3) == 0) begin
        nb = 3'($urandom_range(0, 7));
      end else if (broken && nb == 3'd4 && $urandom_range(0, 2) == 0) begin
        nb = 3'($urandom_range(4, 7));
      end
      put_word($urandom, nb, first ? len_field : 32'($urandom), last);
      first = 1'b0;
    end while (!last);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_push <= 1'b0;
    while (tracker.pending_hashes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_seed(input logic [31:0] value);
    drain_results();
    @(negedge clk);
    cfg_we        <= 1'b1;
    cfg_hash_seed <= value;
    @(posedge clk);
    tracker.hash_seed = value;
    seeds_written++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [31:0] seed_list[6];
    int          phase_words;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // Directed keys under the reset seed of zero.
    put_word(32'h0000_0000, 3'd0, 32'h0000_0000, 1'b1);
    put_word(32'hffff_ffff, 3'd0, 32'hffff_ffff, 1'b1);
    put_word(32'hffff_ffff, 3'd1, 32'h0000_0001, 1'b1);
    put_word(32'h0000_0000, 3'd3, 32'h0000_0009, 1'b1);
    put_word(32'hffff_ffff, 3'd4, 32'h0000_0004, 1'b1);
    put_word(32'ha5a5_a5a5, 3'd7, 32'h0000_0008, 1'b0);
    put_word(32'h5a5a_5a5a, 3'd5, 32'hffff_ffff, 1'b1);
    put_word(32'hffff_ffff, 3'd0, 32'h0000_000c, 1'b0);
    put_word(32'h1234_5678, 3'd6, 32'h0000_0000, 1'b0);
    put_word(32'hdead_beef, 3'd2, 32'h0000_0000, 1'b1);
    put_word(32'h8000_0001, 3'd1, 32'h0000_0008, 1'b0);
    put_word(32'hffff_ff00, 3'd3, 32'h0000_0000, 1'b0);
    put_word(32'h7fff_ffff, 3'd4, 32'h0000_0000, 1'b1);
    put_word(32'h6c6c_6568, 3'd4, 32'h0000_0007, 1'b0);
    put_word(32'h006f_776f, 3'd3, 32'h0000_0000, 1'b1);

    // All-ones seed, including an empty key.
    set_seed(32'hffff_ffff);
    put_word(32'h0000_0000, 3'd0, 32'h0000_0000, 1'b1);
    put_word(32'hffff_ffff, 3'd4, 32'h0000_0005, 1'b0);
    put_word(32'hffff_ffff, 3'd1, 32'h0000_0000, 1'b1);

    seed_list[0] = 32'h0000_0000;
    seed_list[1] = $urandom;
    seed_list[2] = 32'h8000_0000;
    seed_list[3] = $urandom;
    seed_list[4] = 32'h0000_0001;
    seed_list[5] = $urandom;
    for (int phase = 0; phase < 6; phase++) begin
      set_seed(seed_list[phase]);
      idle_on = (phase < 5);
      phase_words = words_sent;
      while (words_sent - phase_words < 240) begin
        if ($urandom_range(0, 19) == 0) begin
          send_key($urandom_range(25, 256), $urandom_range(0, 5) == 0);
        end else begin
          send_key($urandom_range(0, 24), $urandom_range(0, 5) == 0);
        end
      end
    end

    drain_results();
    $display("run covered %0d words in %0d keys under %0d seed settings",
             words_sent, keys_sent, seeds_written + 1);
    $display("%0d hashes checked, %0d mismatches, %0d hashes never delivered",
             tracker.hashes_checked, tracker.mismatches, tracker.pending_hashes.size());
    if (tracker.mismatches == 0 && tracker.pending_hashes.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/mm2_pkg.sv
rtl/mm2_front.sv
rtl/mm2_fifo.sv
rtl/mm2_back.sv
rtl/murmur2_hash_32.sv
test/tb_top.sv
